### hw/rtl/tap_pkg.sv
package tap_pkg;

   localparam int NUM_AXES = 5;
   localparam int SIZE_BITS = 16;
   localparam int INDEX_BITS = 32;
   localparam int ELEM_BITS = 64;

   localparam int ORDER_FIELD_BITS = 3;
   localparam int ORDER_BITS = ORDER_FIELD_BITS * NUM_AXES;
   localparam int AXIS_IDX_BITS = $clog2(NUM_AXES);

   localparam int CSR_INDEX_BITS = $clog2(NUM_AXES + 1);
   localparam int CSR_DATA_BITS = (ORDER_BITS > SIZE_BITS) ? ORDER_BITS : SIZE_BITS;

   // size registers sit at indexes 0..NUM_AXES-1, the order register right after
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_AXIS0 = '0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_ORDER = CSR_INDEX_BITS'(NUM_AXES);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [NUM_AXES-1:0][SIZE_BITS-1:0] size_vec_type;
   typedef logic [NUM_AXES-1:0][INDEX_BITS-1:0] index_vec_type;

   typedef struct packed {
      logic          busy;
      logic          done;
      logic          order_bad;
      size_vec_type  size_m1;
      index_vec_type stride;
   } cfg_status_type;

   typedef struct packed {
      logic [ELEM_BITS-1:0]  value_bits;
      logic [INDEX_BITS-1:0] base;
      index_vec_type         contrib;
      logic                  last_of_tensor;
      logic                  order_error;
   } queue_entry_type;

   typedef enum logic {
      CFG_IDLE,
      CFG_STRIDE
   } cfg_state_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_RESCALE
   } front_state_type;

   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
      return (s == '0) ? SIZE_BITS'(1) : s;
   endfunction

   function automatic logic [SIZE_BITS-1:0] size_minus_one(input logic [SIZE_BITS-1:0] s);
      return (s == '0) ? '0 : s - SIZE_BITS'(1);
   endfunction

   function automatic logic [ORDER_BITS-1:0] identity_order();
      logic [ORDER_BITS-1:0] o;
      o = '0;
      for (int q = 0; q < NUM_AXES; q++) begin
         o[q*ORDER_FIELD_BITS +: ORDER_FIELD_BITS] = ORDER_FIELD_BITS'(q);
      end
      return o;
   endfunction

endpackage

### hw/rtl/tap_if.sv
interface tap_req_if import tap_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ELEM_BITS-1:0] element_bits;
   logic                 first_element;

   modport source (output valid, output element_bits, output first_element, input ready);
   modport sink (input valid, input element_bits, input first_element, output ready);
endinterface

interface tap_rsp_if import tap_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ELEM_BITS-1:0]  value_bits;
   logic [INDEX_BITS-1:0] dest_index;
   logic                  last_of_tensor;
   logic                  order_error;

   modport source (output valid, output value_bits, output dest_index, output last_of_tensor,
                   output order_error, input ready);
   modport sink (input valid, input value_bits, input dest_index, input last_of_tensor,
                 input order_error, output ready);
endinterface

### hw/rtl/tap_cfg.sv
module tap_cfg import tap_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_status_type            cfg_status
);

   logic [SIZE_BITS-1:0]        size_ff [NUM_AXES];
   logic [ORDER_BITS-1:0]       order_ff;
   logic [INDEX_BITS-1:0]       stride_ff [NUM_AXES];
   logic [INDEX_BITS-1:0]       prod_ff;
   logic [AXIS_IDX_BITS-1:0]    step_ff;
   logic                        done_ff;
   cfg_state_type               state_ff, state_in;

   logic [ORDER_FIELD_BITS-1:0] field [NUM_AXES];
   logic [AXIS_IDX_BITS-1:0]    perm [NUM_AXES];
   logic                        order_bad;
   logic                        write_size, write_order, write_hit;
   logic [AXIS_IDX_BITS-1:0]    step_axis;
   logic [SIZE_BITS-1:0]        step_size;
   logic [INDEX_BITS+SIZE_BITS-1:0] prod_full;

   // axis order check: out of range or repeated field falls back to identity
   always_comb begin
      order_bad = 1'b0;
      for (int q = 0; q < NUM_AXES; q++) begin
         field[q] = order_ff[q*ORDER_FIELD_BITS +: ORDER_FIELD_BITS];
      end
      for (int q = 0; q < NUM_AXES; q++) begin
         if (int'(field[q]) >= NUM_AXES) order_bad = 1'b1;
         for (int r = 0; r < q; r++) begin
            if (field[q] == field[r]) order_bad = 1'b1;
         end
      end
      for (int q = 0; q < NUM_AXES; q++) begin
         perm[q] = order_bad ? AXIS_IDX_BITS'(q) : field[q][AXIS_IDX_BITS-1:0];
      end
   end

   assign write_size  = csr_wr_en && (csr_index < CSR_AXIS_ORDER) &&
                        (csr_index >= CSR_SIZE_AXIS0);
   assign write_order = csr_wr_en && (csr_index == CSR_AXIS_ORDER);
   assign write_hit   = write_size || write_order;

   // strides walk from the fastest destination position, one multiply per cycle
   assign step_axis = perm[step_ff];
   assign step_size = eff_size(size_ff[step_axis]);
   assign prod_full = prod_ff * step_size;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CFG_IDLE: begin
            if (write_hit) state_in = CFG_STRIDE;
         end
         CFG_STRIDE: begin
            if (write_hit) state_in = CFG_STRIDE;
            else if (step_ff == '0) state_in = CFG_IDLE;
         end
         default: state_in = CFG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            size_ff[a]   <= SIZE_BITS'(1);
            stride_ff[a] <= INDEX_BITS'(1);
         end
         order_ff <= identity_order();
         state_ff <= CFG_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
         prod_ff  <= INDEX_BITS'(1);
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == CFG_STRIDE) && !write_hit && (step_ff == '0);
         if (write_size) size_ff[csr_index[AXIS_IDX_BITS-1:0]] <= csr_wdata[SIZE_BITS-1:0];
         if (write_order) order_ff <= csr_wdata[ORDER_BITS-1:0];
         if (write_hit) begin
            step_ff <= AXIS_IDX_BITS'(NUM_AXES - 1);
            prod_ff <= INDEX_BITS'(1);
         end else if (state_ff == CFG_STRIDE) begin
            stride_ff[step_axis] <= prod_ff;
            prod_ff              <= prod_full[INDEX_BITS-1:0];
            step_ff              <= step_ff - 1'b1;
         end
      end
   end

   always_comb begin
      cfg_status.busy      = (state_ff == CFG_STRIDE);
      cfg_status.done      = done_ff;
      cfg_status.order_bad = order_bad;
      for (int a = 0; a < NUM_AXES; a++) begin
         cfg_status.size_m1[a] = size_minus_one(size_ff[a]);
         cfg_status.stride[a]  = stride_ff[a];
      end
   end

endmodule

### hw/rtl/tap_front.sv
module tap_front import tap_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   tap_req_if.sink         req_ch,
   input  cfg_status_type  cfg_status,
   input  logic            queue_full,
   output logic            queue_push,
   output queue_entry_type queue_entry
);

   // dest offset is kept as base + sum of per-axis terms (counter * stride);
   // the back end adds the terms up
   logic [SIZE_BITS-1:0]     cnt_ff [NUM_AXES];
   logic [INDEX_BITS-1:0]    contrib_ff [NUM_AXES];
   logic [INDEX_BITS-1:0]    base_ff;
   front_state_type          state_ff, state_in;
   logic [AXIS_IDX_BITS-1:0] axis_ff;
   logic                     pend_valid_ff;
   logic [AXIS_IDX_BITS-1:0] pend_axis_ff;
   logic [INDEX_BITS-1:0]    pend_prod_ff;

   logic [SIZE_BITS-1:0]     cnt_e [NUM_AXES];
   logic [INDEX_BITS-1:0]    contrib_e [NUM_AXES];
   logic [INDEX_BITS-1:0]    base_e;
   logic [NUM_AXES-1:0]      at_last;
   logic [NUM_AXES-1:0]      carry;
   logic [SIZE_BITS-1:0]     cnt_in [NUM_AXES];
   logic [INDEX_BITS-1:0]    contrib_in [NUM_AXES];
   logic [INDEX_BITS+SIZE_BITS-1:0] mul_full;
   logic                     busy;
   logic                     accept;

   localparam logic [AXIS_IDX_BITS-1:0] LAST_AXIS = AXIS_IDX_BITS'(NUM_AXES - 1);

   always_comb begin
      base_e = req_ch.first_element ? '0 : base_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         cnt_e[a]     = req_ch.first_element ? '0 : cnt_ff[a];
         contrib_e[a] = req_ch.first_element ? '0 : contrib_ff[a];
         at_last[a]   = (cnt_e[a] >= cfg_status.size_m1[a]);
      end
      carry[NUM_AXES-1] = 1'b1;
      for (int a = NUM_AXES - 2; a >= 0; a--) begin
         carry[a] = carry[a+1] && at_last[a+1];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         if (!carry[a]) begin
            cnt_in[a]     = cnt_e[a];
            contrib_in[a] = contrib_e[a];
         end else if (at_last[a]) begin
            cnt_in[a]     = '0;
            contrib_in[a] = '0;
         end else begin
            cnt_in[a]     = cnt_e[a] + SIZE_BITS'(1);
            contrib_in[a] = contrib_e[a] + cfg_status.stride[a];
         end
      end
   end

   assign busy         = (state_ff != FRONT_IDLE) || pend_valid_ff;
   assign req_ch.ready = !busy && !cfg_status.busy && !cfg_status.done && !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign queue_push   = accept;

   always_comb begin
      queue_entry.value_bits     = req_ch.element_bits;
      queue_entry.base           = base_e;
      queue_entry.last_of_tensor = &at_last;
      queue_entry.order_error    = cfg_status.order_bad;
      for (int a = 0; a < NUM_AXES; a++) begin
         queue_entry.contrib[a] = contrib_e[a];
      end
   end

   // after new strides, rebuild each term from its counter and fold the change into base
   assign mul_full = cfg_status.stride[axis_ff] * cnt_ff[axis_ff];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (cfg_status.done) state_in = FRONT_RESCALE;
         end
         FRONT_RESCALE: begin
            if (cfg_status.busy || axis_ff == LAST_AXIS) state_in = FRONT_IDLE;
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            cnt_ff[a]     <= '0;
            contrib_ff[a] <= '0;
         end
         base_ff       <= '0;
         state_ff      <= FRONT_IDLE;
         axis_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= (state_ff == FRONT_RESCALE) && !cfg_status.busy;
         if (accept) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               cnt_ff[a]     <= cnt_in[a];
               contrib_ff[a] <= contrib_in[a];
            end
            base_ff <= base_e;
         end
         if (pend_valid_ff && !cfg_status.busy) begin
            contrib_ff[pend_axis_ff] <= pend_prod_ff;
            base_ff <= base_ff + contrib_ff[pend_axis_ff] - pend_prod_ff;
         end
         if (state_ff == FRONT_RESCALE) begin
            axis_ff <= (axis_ff == LAST_AXIS) ? '0 : axis_ff + 1'b1;
         end else begin
            axis_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FRONT_RESCALE) begin
         pend_prod_ff <= mul_full[INDEX_BITS-1:0];
         pend_axis_ff <= axis_ff;
      end
   end

endmodule

### hw/rtl/tap_queue.sv
module tap_queue import tap_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output queue_entry_type pop_entry,
   output logic            empty
);

   localparam logic [QUEUE_PTR_BITS-1:0] LAST_SLOT = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);

   queue_entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0]   count_ff;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

### hw/rtl/tap_back.sv
module tap_back import tap_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_empty,
   input  queue_entry_type queue_entry,
   output logic            queue_pop,
   tap_rsp_if.source       rsp_ch
);

   // registered adder tree over base and the per-axis terms
   localparam int TREE_TERMS  = NUM_AXES + 1;
   localparam int TREE_LEVELS = $clog2(TREE_TERMS);
   localparam int TREE_LEAVES = 1 << TREE_LEVELS;
   localparam int TREE_HALF   = TREE_LEAVES / 2;

   logic [INDEX_BITS-1:0] src [TREE_LEVELS][TREE_LEAVES];
   logic [INDEX_BITS-1:0] node_ff [TREE_LEVELS][TREE_HALF];
   logic [ELEM_BITS-1:0]  value_ff [TREE_LEVELS];
   logic                  last_ff [TREE_LEVELS];
   logic                  err_ff [TREE_LEVELS];
   logic                  vld_ff [TREE_LEVELS];
   logic                  advance;

   always_comb begin
      src[0][0] = queue_entry.base;
      for (int a = 0; a < NUM_AXES; a++) begin
         src[0][a+1] = queue_entry.contrib[a];
      end
      for (int i = NUM_AXES + 1; i < TREE_LEAVES; i++) begin
         src[0][i] = '0;
      end
      for (int l = 1; l < TREE_LEVELS; l++) begin
         for (int i = 0; i < TREE_LEAVES; i++) begin
            src[l][i] = (i < TREE_HALF) ? node_ff[l-1][i] : '0;
         end
      end
   end

   // whole tree moves together; output stage doubles as the result register
   assign advance   = !vld_ff[TREE_LEVELS-1] || rsp_ch.ready;
   assign queue_pop = advance && !queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < TREE_LEVELS; l++) begin
            vld_ff[l] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= queue_pop;
         for (int l = 1; l < TREE_LEVELS; l++) begin
            vld_ff[l] <= vld_ff[l-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < TREE_LEVELS; l++) begin
            for (int j = 0; j < TREE_HALF; j++) begin
               node_ff[l][j] <= src[l][2*j] + src[l][2*j+1];
            end
         end
         value_ff[0] <= queue_entry.value_bits;
         last_ff[0]  <= queue_entry.last_of_tensor;
         err_ff[0]   <= queue_entry.order_error;
         for (int l = 1; l < TREE_LEVELS; l++) begin
            value_ff[l] <= value_ff[l-1];
            last_ff[l]  <= last_ff[l-1];
            err_ff[l]   <= err_ff[l-1];
         end
      end
   end

   assign rsp_ch.valid          = vld_ff[TREE_LEVELS-1];
   assign rsp_ch.dest_index     = node_ff[TREE_LEVELS-1][0];
   assign rsp_ch.value_bits     = value_ff[TREE_LEVELS-1];
   assign rsp_ch.last_of_tensor = last_ff[TREE_LEVELS-1];
   assign rsp_ch.order_error    = err_ff[TREE_LEVELS-1];

endmodule

### hw/rtl/tensor_axis_permute_addr_gen_core.sv
// Throughput: one item per cycle while not stalled by rsp back-pressure or by a size or order
//   write; the front odometer updates every term in parallel. A result passes the queue and
//   the registered adder tree that sums base and per-axis terms.
// A size or order write stalls req while strides are rebuilt: one stride multiply
//   per axis, then one term rebuild per axis. Sync reset: sizes 1, identity order,
//   strides 1, counters and offset 0, queue and output empty.
module tensor_axis_permute_addr_gen_core import tap_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   tap_req_if.sink                   req_ch,
   tap_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_status_type  cfg_status;
   logic            queue_push, queue_full, queue_pop, queue_empty;
   queue_entry_type push_entry, pop_entry;

   tap_cfg u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg_status (cfg_status)
   );

   tap_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .cfg_status  (cfg_status),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   tap_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   tap_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_entry (pop_entry),
      .queue_pop   (queue_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

### bench/tensor_axis_permute_addr_gen_core_test.sv
`timescale 1ns / 1ps

module tensor_axis_permute_addr_gen_core_test;
   import tap_pkg::*;

   localparam int SETTLE_CYCLES = 2 * NUM_AXES + 6;
   localparam int DRAIN_TAIL = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = '1;

   typedef struct {
      logic [ELEM_BITS-1:0]  value_bits;
      logic [INDEX_BITS-1:0] dest_index;
      logic                  last_of_tensor;
      logic                  order_error;
   } placement_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   tap_req_if req_ch ();
   tap_rsp_if rsp_ch ();

   tensor_axis_permute_addr_gen_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the address generator
   size_vec_type          cfg_extent;
   logic [ORDER_BITS-1:0] cfg_axis_order;
   logic                  cfg_order_bad;
   index_vec_type         axis_stride;
   size_vec_type          axis_count;
   logic [INDEX_BITS-1:0] dest_offset;

   placement_type pending_placements[$];
   placement_type want;
   int fault_count;

   bit sender_idling;
   bit receiver_idling;
   int rsp_hold_request;
   int rsp_hold_left;
   int rsp_stall_left;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [SIZE_BITS-1:0] effective_extent(input int a);
      return (cfg_extent[a] == '0) ? SIZE_BITS'(1) : cfg_extent[a];
   endfunction

   function automatic void rebuild_strides();
      int perm [NUM_AXES];
      bit seen [NUM_AXES];
      logic [ORDER_FIELD_BITS-1:0] f;
      logic [INDEX_BITS-1:0] prod;
      cfg_order_bad = 1'b0;
      prod = INDEX_BITS'(1);
      for (int q = 0; q < NUM_AXES; q++) seen[q] = 1'b0;
      for (int q = 0; q < NUM_AXES; q++) begin
         f = cfg_axis_order[q*ORDER_FIELD_BITS +: ORDER_FIELD_BITS];
         if (f >= NUM_AXES || seen[f]) begin
            cfg_order_bad = 1'b1;
         end else begin
            seen[f] = 1'b1;
         end
         perm[q] = int'(f) % NUM_AXES;
      end
      // malformed order falls back to identity
      if (cfg_order_bad) begin
         for (int q = 0; q < NUM_AXES; q++) perm[q] = q;
      end
      for (int q = NUM_AXES - 1; q >= 0; q--) begin
         axis_stride[perm[q]] = prod;
         prod = prod * INDEX_BITS'(effective_extent(perm[q]));
      end
   endfunction

   function automatic void reset_shadow();
      cfg_axis_order = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         cfg_extent[a] = SIZE_BITS'(1);
         axis_count[a] = '0;
         cfg_axis_order[a*ORDER_FIELD_BITS +: ORDER_FIELD_BITS] = ORDER_FIELD_BITS'(a);
      end
      dest_offset = '0;
      rebuild_strides();
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                          input logic [CSR_DATA_BITS-1:0] data);
      if (idx < CSR_AXIS_ORDER) begin
         cfg_extent[idx] = data[SIZE_BITS-1:0];
         rebuild_strides();
      end else if (idx == CSR_AXIS_ORDER) begin
         cfg_axis_order = data[ORDER_BITS-1:0];
         rebuild_strides();
      end
   endfunction

   // placement of one accepted element, then odometer advance
   function automatic void predict_placement(input logic [ELEM_BITS-1:0] bits, input logic first);
      placement_type p;
      logic at_end;
      logic carry;
      if (first) begin
         axis_count = '0;
         dest_offset = '0;
      end
      at_end = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (axis_count[a] < effective_extent(a) - SIZE_BITS'(1)) at_end = 1'b0;
      end
      p.value_bits = bits;
      p.dest_index = dest_offset;
      p.last_of_tensor = at_end;
      p.order_error = cfg_order_bad;
      pending_placements.push_back(p);
      carry = 1'b1;
      for (int a = NUM_AXES - 1; a >= 0; a--) begin
         if (carry) begin
            if (axis_count[a] >= effective_extent(a) - SIZE_BITS'(1)) begin
               dest_offset = dest_offset - INDEX_BITS'(axis_count[a]) * axis_stride[a];
               axis_count[a] = '0;
            end else begin
               axis_count[a] = axis_count[a] + SIZE_BITS'(1);
               dest_offset = dest_offset + axis_stride[a];
               carry = 1'b0;
            end
         end
      end
   endfunction

   function automatic logic [ORDER_BITS-1:0] pack_order(input int f0, input int f1, input int f2,
                                                        input int f3, input int f4);
      return {ORDER_FIELD_BITS'(f4), ORDER_FIELD_BITS'(f3), ORDER_FIELD_BITS'(f2),
              ORDER_FIELD_BITS'(f1), ORDER_FIELD_BITS'(f0)};
   endfunction

   function automatic logic [ORDER_BITS-1:0] shuffled_order(input bit with_repeat);
      int field [NUM_AXES];
      int j;
      int t;
      logic [ORDER_BITS-1:0] o;
      for (int q = 0; q < NUM_AXES; q++) field[q] = q;
      for (int q = NUM_AXES - 1; q > 0; q--) begin
         j = $urandom_range(0, q);
         t = field[q];
         field[q] = field[j];
         field[j] = t;
      end
      if (with_repeat) begin
         field[$urandom_range(0, NUM_AXES - 1)] = field[$urandom_range(0, NUM_AXES - 1)];
      end
      o = '0;
      for (int q = 0; q < NUM_AXES; q++) begin
         o[q*ORDER_FIELD_BITS +: ORDER_FIELD_BITS] = ORDER_FIELD_BITS'(field[q]);
      end
      return o;
   endfunction

   function automatic logic [SIZE_BITS-1:0] random_extent();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2: return SIZE_BITS'($urandom_range(0, 16'hFFFF));
         default: return SIZE_BITS'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [ELEM_BITS-1:0] random_element();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_element(input logic [ELEM_BITS-1:0] bits, input logic first);
      int gap;
      @(negedge clock);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.element_bits = bits;
      req_ch.first_element = first;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_placement(bits, first);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      apply_register(idx, data);
      // stride rebuild keeps the block busy for a while
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure_tensor(input int s0, input int s1, input int s2, input int s3,
                                   input int s4, input logic [CSR_DATA_BITS-1:0] order);
      wait_for_drain();
      write_register(CSR_SIZE_AXIS0 + CSR_INDEX_BITS'(0), CSR_DATA_BITS'(s0));
      write_register(CSR_SIZE_AXIS0 + CSR_INDEX_BITS'(1), CSR_DATA_BITS'(s1));
      write_register(CSR_SIZE_AXIS0 + CSR_INDEX_BITS'(2), CSR_DATA_BITS'(s2));
      write_register(CSR_SIZE_AXIS0 + CSR_INDEX_BITS'(3), CSR_DATA_BITS'(s3));
      write_register(CSR_SIZE_AXIS0 + CSR_INDEX_BITS'(4), CSR_DATA_BITS'(s4));
      write_register(CSR_AXIS_ORDER, order);
   endtask

   task automatic configure_random();
      logic [CSR_DATA_BITS-1:0] order;
      case ($urandom_range(0, 7))
         0: order = CSR_DATA_BITS'($urandom_range(0, 16'hFFFF));
         1: order = CSR_DATA_BITS'(shuffled_order(1'b1));
         default: order = CSR_DATA_BITS'(shuffled_order(1'b0));
      endcase
      configure_tensor(random_extent(), random_extent(), random_extent(), random_extent(),
                       random_extent(), order);
   endtask

   task automatic test_reset_state();
      send_element('0, 1'b1);
      send_element('1, 1'b0);
      send_element(64'hAAAA_AAAA_5555_5555, 1'b1);
   endtask

   task automatic test_reversed_order();
      configure_tensor(2, 1, 1, 1, 3, pack_order(4, 3, 2, 1, 0));
      send_element(random_element(), 1'b1);
      repeat (6) send_element(random_element(), 1'b0);
   endtask

   task automatic test_zero_extent();
      configure_tensor(2, 0, 1, 1, 0, pack_order(1, 0, 2, 4, 3));
      send_element(random_element(), 1'b1);
      send_element(random_element(), 1'b0);
   endtask

   task automatic test_bad_order();
      // field naming an axis out of range, with the unused top data bit set
      configure_tensor(2, 1, 3, 1, 1, {1'b1, pack_order(7, 1, 2, 3, 4)});
      send_element(random_element(), 1'b1);
      send_element(random_element(), 1'b0);
      // repeated axis
      configure_tensor(2, 1, 3, 1, 1, pack_order(0, 0, 2, 3, 4));
      send_element(random_element(), 1'b1);
      send_element(random_element(), 1'b0);
   endtask

   task automatic test_midtensor_resize();
      configure_tensor(1, 1, 1, 4, 3, pack_order(3, 4, 0, 1, 2));
      send_element(random_element(), 1'b1);
      repeat (4) send_element(random_element(), 1'b0);
      // counters now sit beyond the new final values
      configure_tensor(1, 1, 1, 1, 2, pack_order(3, 4, 0, 1, 2));
      repeat (2) send_element(random_element(), 1'b0);
   endtask

   task automatic test_index_wrap();
      configure_tensor(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       pack_order(4, 0, 1, 2, 3));
      write_register(CSR_UNMAPPED, CSR_DATA_BITS'($urandom));
      send_element(random_element(), 1'b1);
      repeat (2) send_element(random_element(), 1'b0);
   endtask

   task automatic test_backpressure();
      configure_tensor(1, 1, 2, 3, 4, pack_order(2, 4, 3, 0, 1));
      sender_idling = 1'b0;
      rsp_hold_request = 150;
      send_element(random_element(), 1'b1);
      repeat (39) send_element(random_element(), 1'b0);
      wait_for_drain();
      sender_idling = 1'b1;
   endtask

   task automatic test_random_tensors(input int item_goal);
      int sent;
      int n;
      sent = 0;
      while (sent < item_goal) begin
         configure_random();
         n = $urandom_range(12, 40);
         // most phases start a fresh tensor, some continue with stale counters
         send_element(random_element(), ($urandom_range(0, 3) != 0));
         repeat (n - 1) send_element(random_element(), ($urandom_range(0, 23) == 0));
         sent += n;
      end
   endtask

   task automatic test_steady_stream();
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      configure_random();
      send_element(random_element(), 1'b1);
      repeat (59) send_element(random_element(), ($urandom_range(0, 23) == 0));
   endtask

   // result sink ready with random stalls and one long hold
   initial begin
      rsp_ch.ready = 1'b0;
      rsp_hold_left = 0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            rsp_hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (receiver_idling && $urandom_range(0, 6) == 0) rsp_stall_left = $urandom_range(1, 13);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_placements.size() == 0) begin
            $error("unexpected item: dest_index %h value_bits %h", rsp_ch.dest_index,
                   rsp_ch.value_bits);
            fault_count++;
         end else begin
            want = pending_placements.pop_front();
            if (rsp_ch.value_bits !== want.value_bits) begin
               $error("value_bits expected %h actual %h", want.value_bits, rsp_ch.value_bits);
               fault_count++;
            end
            if (rsp_ch.dest_index !== want.dest_index) begin
               $error("dest_index expected %h actual %h", want.dest_index, rsp_ch.dest_index);
               fault_count++;
            end
            if (rsp_ch.last_of_tensor !== want.last_of_tensor) begin
               $error("last_of_tensor expected %b actual %b", want.last_of_tensor,
                      rsp_ch.last_of_tensor);
               fault_count++;
            end
            if (rsp_ch.order_error !== want.order_error) begin
               $error("order_error expected %b actual %b", want.order_error, rsp_ch.order_error);
               fault_count++;
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("FAIL tensor_axis_permute_addr_gen_core");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.element_bits = '0;
      req_ch.first_element = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fault_count = 0;
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      rsp_hold_request = 0;
      reset_shadow();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_reversed_order();
      test_zero_extent();
      test_bad_order();
      test_midtensor_resize();
      test_index_wrap();
      test_backpressure();
      test_random_tensors(270);
      test_steady_stream();

      wait_for_drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS tensor_axis_permute_addr_gen_core");
      end else begin
         $display("FAIL tensor_axis_permute_addr_gen_core");
      end
      $finish;
   end

endmodule
